// File: design/ccircle_pkg.sv
// Package: widths, pipeline schedule and word types for the circumcircle pipeline.
`timescale 1ns / 1ps

package ccircle_pkg;

    // Input and output formats
    localparam int COORD_BITS       = 12;
    localparam int RADIUS_FRAC_BITS = 4;
    localparam int CTR_W            = 24;
    localparam int RAD_W            = 28;

    // Derived internal widths
    localparam int DW   = COORD_BITS + 1;          // signed coordinate difference
    localparam int UW   = 2 * COORD_BITS + 1;      // sum of two squares, unsigned
    localparam int DETW = 2 * DW + 1;              // signed determinant
    localparam int DNW  = DETW + 1;                // 2*|det|, unsigned
    localparam int NXW  = UW + DW + 2;             // signed centre numerator
    localparam int PW   = 3 * UW;                  // product of three squared sides
    localparam int SRW  = (PW + 2 * RADIUS_FRAC_BITS + 1) / 2;  // root width
    localparam int SW2  = 2 * SRW;                 // radicand width

    // Compare widths for the restoring dividers
    localparam int CCW  = DNW + CTR_W + NXW;
    localparam int RCW  = DNW + RAD_W + SRW;

    // Iterative stages: sqrt steps, radius overflow check, radius quotient bits
    localparam int NI   = SRW + 1 + RAD_W;

    localparam logic signed [CTR_W-1:0] CTR_MAX = {1'b0, {(CTR_W-1){1'b1}}};
    localparam logic signed [CTR_W-1:0] CTR_MIN = {1'b1, {(CTR_W-1){1'b0}}};
    localparam logic [RAD_W-1:0]        RAD_MAX = {RAD_W{1'b1}};

    // Word carried through the iterative stages
    typedef struct packed {
        logic             valid;
        logic             deg;
        logic             sx;
        logic             sy;
        logic             cxo;
        logic             cyo;
        logic [NXW-1:0]   nxr;
        logic [NXW-1:0]   nyr;
        logic [DNW-1:0]   den;
        logic [CTR_W-1:0] qx;
        logic [CTR_W-1:0] qy;
        logic [SW2-1:0]   s;
        logic [SRW+1:0]   srem;
        logic [SRW-1:0]   root;
        logic             rovf;
        logic [SRW-1:0]   rrem;
        logic [RAD_W-1:0] rq;
    } t_item;

    // Finished result word
    typedef struct packed {
        logic signed [CTR_W-1:0] center_x;
        logic signed [CTR_W-1:0] center_y;
        logic [RAD_W-1:0]        radius_q4;
        logic                    degenerate;
        logic                    saturated;
    } t_res;

endpackage

// File: design/circumcircle_from_three_points.sv
// Top level: pipelined circumcircle (centre and radius) of three integer points.
`timescale 1ns / 1ps

// Fully pipelined: one word enters per cycle while o_stall is low; each word
// passes the front stages, the iterative stages and then the output buffer.
// Five front stages form the differences, squares, determinant, numerators and
// the radicand; then a chain of register stages runs a bit-per-stage square root
// of the radicand next to two bit-per-stage center dividers, and finally a
// bit-per-stage radius divider. A two-word output buffer takes results; o_stall
// is high only while that buffer is full, and then the whole pipe holds.
// Collinear points give a zero circle with the degenerate flag.
module circumcircle_from_three_points (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [ccircle_pkg::COORD_BITS-1:0]    i_first_x,
    input  logic [ccircle_pkg::COORD_BITS-1:0]    i_first_y,
    input  logic [ccircle_pkg::COORD_BITS-1:0]    i_second_x,
    input  logic [ccircle_pkg::COORD_BITS-1:0]    i_second_y,
    input  logic [ccircle_pkg::COORD_BITS-1:0]    i_third_x,
    input  logic [ccircle_pkg::COORD_BITS-1:0]    i_third_y,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [ccircle_pkg::CTR_W-1:0]  o_center_x,
    output logic signed [ccircle_pkg::CTR_W-1:0]  o_center_y,
    output logic [ccircle_pkg::RAD_W-1:0]         o_radius_q4,
    output logic                                  o_degenerate,
    output logic                                  o_saturated
);

    localparam int DW  = ccircle_pkg::DW;
    localparam int UW  = ccircle_pkg::UW;
    localparam int NI  = ccircle_pkg::NI;
    localparam int SRW = ccircle_pkg::SRW;
    localparam int SW2 = ccircle_pkg::SW2;
    localparam int NXW = ccircle_pkg::NXW;
    localparam int DNW = ccircle_pkg::DNW;
    localparam int DETW = ccircle_pkg::DETW;
    localparam int PW  = ccircle_pkg::PW;
    localparam int CQW = ccircle_pkg::CTR_W;
    localparam int RQW = ccircle_pkg::RAD_W;
    localparam int CCW = ccircle_pkg::CCW;
    localparam int RCW = ccircle_pkg::RCW;

    typedef struct packed {
        logic                 valid;
        logic signed [DW-1:0] ax, ay, bx, by, cx, cy;
        logic [UW-1:0]        s1, s2, s3;
    } t_sa;

    typedef struct packed {
        logic                   valid;
        logic signed [2*DW-1:0] p1, p2;
        logic signed [UW:0]     bc2, cd2;
        logic signed [DW-1:0]   ax, ay, bx, by;
        logic [UW-1:0]          uu, vv, ww;
    } t_sb;

    typedef struct packed {
        logic                     valid;
        logic signed [DETW-1:0]   det;
        logic signed [UW+DW:0]    m1, m2, m3, m4;
        logic [2*UW-1:0]          uv;
        logic [UW-1:0]            ww;
    } t_sc;

    typedef struct packed {
        logic                   valid;
        logic signed [DETW-1:0] det;
        logic signed [NXW-1:0]  nx, ny;
        logic [2*UW-1:0]        pl, ph;
    } t_sd;

    logic adv;
    t_sa  r_a, n_a;
    t_sb  r_b, n_b;
    t_sc  r_c, n_c;
    t_sd  r_d, n_d;
    ccircle_pkg::t_item r_pipe [0:NI];
    ccircle_pkg::t_item n_pipe [0:NI];

    // Output buffer
    ccircle_pkg::t_res r_buf [0:1];
    ccircle_pkg::t_res n_res;
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       push, pop;

    assign adv     = (r_cnt != 2'd2);
    assign o_stall = !adv;

    // Stage A: differences and squared norms
    always_comb begin
        logic signed [DW-1:0] x1, y1, x2, y2, x3, y3;
        x1 = $signed({1'b0, i_first_x});
        y1 = $signed({1'b0, i_first_y});
        x2 = $signed({1'b0, i_second_x});
        y2 = $signed({1'b0, i_second_y});
        x3 = $signed({1'b0, i_third_x});
        y3 = $signed({1'b0, i_third_y});
        n_a.valid = i_valid;
        n_a.ax = x1 - x2;
        n_a.ay = y1 - y2;
        n_a.bx = x2 - x3;
        n_a.by = y2 - y3;
        n_a.cx = x1 - x3;
        n_a.cy = y1 - y3;
        n_a.s1 = UW'(i_first_x) * UW'(i_first_x) + UW'(i_first_y) * UW'(i_first_y);
        n_a.s2 = UW'(i_second_x) * UW'(i_second_x) + UW'(i_second_y) * UW'(i_second_y);
        n_a.s3 = UW'(i_third_x) * UW'(i_third_x) + UW'(i_third_y) * UW'(i_third_y);
    end

    // Stage B: determinant products, square differences, side lengths squared
    always_comb begin
        logic signed [2*DW:0] tu, tv, tw;
        tu = r_a.ax * r_a.ax + r_a.ay * r_a.ay;
        tv = r_a.bx * r_a.bx + r_a.by * r_a.by;
        tw = r_a.cx * r_a.cx + r_a.cy * r_a.cy;
        n_b.valid = r_a.valid;
        n_b.p1  = r_a.ax * r_a.by;
        n_b.p2  = r_a.bx * r_a.ay;
        n_b.bc2 = $signed({1'b0, r_a.s1}) - $signed({1'b0, r_a.s2});
        n_b.cd2 = $signed({1'b0, r_a.s2}) - $signed({1'b0, r_a.s3});
        n_b.ax = r_a.ax;
        n_b.ay = r_a.ay;
        n_b.bx = r_a.bx;
        n_b.by = r_a.by;
        n_b.uu = tu[UW-1:0];
        n_b.vv = tv[UW-1:0];
        n_b.ww = tw[UW-1:0];
    end

    // Stage C: determinant, numerator products, first radicand product
    always_comb begin
        n_c.valid = r_b.valid;
        n_c.det = DETW'(r_b.p1) - DETW'(r_b.p2);
        n_c.m1  = r_b.bc2 * r_b.by;
        n_c.m2  = r_b.cd2 * r_b.ay;
        n_c.m3  = r_b.cd2 * r_b.ax;
        n_c.m4  = r_b.bc2 * r_b.bx;
        n_c.uv  = (2*UW)'(r_b.uu) * (2*UW)'(r_b.vv);
        n_c.ww  = r_b.ww;
    end

    // Stage D: numerators and split partial products of the radicand
    always_comb begin
        n_d.valid = r_c.valid;
        n_d.det = r_c.det;
        n_d.nx  = NXW'(r_c.m1) - NXW'(r_c.m2);
        n_d.ny  = NXW'(r_c.m3) - NXW'(r_c.m4);
        n_d.pl  = (2*UW)'(r_c.uv[UW-1:0]) * (2*UW)'(r_c.ww);
        n_d.ph  = (2*UW)'(r_c.uv[2*UW-1:UW]) * (2*UW)'(r_c.ww);
    end

    // Stage E: magnitudes, signs, divisor and scaled radicand
    always_comb begin
        logic [PW-1:0]   prod;
        logic [DETW-1:0] adet;
        logic            dneg;
        prod = (PW'(r_d.ph) << UW) + PW'(r_d.pl);
        dneg = r_d.det[DETW-1];
        adet = dneg ? DETW'(-r_d.det) : DETW'(r_d.det);
        n_pipe[0]       = '0;
        n_pipe[0].valid = r_d.valid;
        n_pipe[0].deg   = (r_d.det == '0);
        n_pipe[0].sx    = r_d.nx[NXW-1] ^ dneg;
        n_pipe[0].sy    = r_d.ny[NXW-1] ^ dneg;
        n_pipe[0].nxr   = r_d.nx[NXW-1] ? NXW'(-r_d.nx) : NXW'(r_d.nx);
        n_pipe[0].nyr   = r_d.ny[NXW-1] ? NXW'(-r_d.ny) : NXW'(r_d.ny);
        n_pipe[0].den   = DNW'(adet) << 1;
        n_pipe[0].s     = SW2'(prod) << (2 * ccircle_pkg::RADIUS_FRAC_BITS);
    end

    // Iterative stages: root, center quotients, radius quotient, one bit each
    for (genvar k = 1; k <= NI; k++) begin : g_stage
        localparam int J  = k - 1;
        localparam int CI = (J >= 1 && J <= CQW) ? CQW - J : 0;
        localparam int RI = (J > SRW) ? RQW - 1 - (J - SRW - 1) : 0;
        always_comb begin
            logic [SRW+1:0] t, trial;
            ccircle_pkg::t_item p;
            p = r_pipe[k-1];
            n_pipe[k] = p;
            t     = {p.srem[SRW-1:0], p.s[SW2-1:SW2-2]};
            trial = {p.root, 2'b01};
            // center overflow check, then one quotient bit per stage
            if (J == 0) begin
                n_pipe[k].cxo = CCW'(p.nxr) >= (CCW'(p.den) << CQW);
                n_pipe[k].cyo = CCW'(p.nyr) >= (CCW'(p.den) << CQW);
            end else if (J <= CQW) begin
                if (CCW'(p.nxr) >= (CCW'(p.den) << CI)) begin
                    n_pipe[k].nxr    = NXW'(CCW'(p.nxr) - (CCW'(p.den) << CI));
                    n_pipe[k].qx[CI] = 1'b1;
                end
                if (CCW'(p.nyr) >= (CCW'(p.den) << CI)) begin
                    n_pipe[k].nyr    = NXW'(CCW'(p.nyr) - (CCW'(p.den) << CI));
                    n_pipe[k].qy[CI] = 1'b1;
                end
            end
            // restoring square root, two radicand bits per stage
            if (J < SRW) begin
                n_pipe[k].s = p.s << 2;
                if (t >= trial) begin
                    n_pipe[k].srem = t - trial;
                    n_pipe[k].root = {p.root[SRW-2:0], 1'b1};
                end else begin
                    n_pipe[k].srem = t;
                    n_pipe[k].root = {p.root[SRW-2:0], 1'b0};
                end
            end else if (J == SRW) begin
                n_pipe[k].rovf = RCW'(p.root) >= (RCW'(p.den) << RQW);
                n_pipe[k].rrem = p.root;
            end else begin
                if (RCW'(p.rrem) >= (RCW'(p.den) << RI)) begin
                    n_pipe[k].rrem   = SRW'(RCW'(p.rrem) - (RCW'(p.den) << RI));
                    n_pipe[k].rq[RI] = 1'b1;
                end
            end
        end
    end

    // Pipeline registers: the whole pipe moves when the output buffer has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_d.valid <= 1'b0;
            for (int i = 0; i <= NI; i++) begin
                r_pipe[i].valid <= 1'b0;
            end
        end else if (adv) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            for (int i = 0; i <= NI; i++) begin
                r_pipe[i] <= n_pipe[i];
            end
        end
    end

    // Result word: sign, clipping and the collinear case
    // A magnitude of 2^23 fits only when negative.
    always_comb begin
        ccircle_pkg::t_item f;
        logic sat;
        f   = r_pipe[NI];
        sat = 1'b0;
        if (f.cxo || (f.qx[CQW-1] && (!f.sx || (f.qx[CQW-2:0] != '0)))) begin
            n_res.center_x = f.sx ? ccircle_pkg::CTR_MIN : ccircle_pkg::CTR_MAX;
            sat = 1'b1;
        end else begin
            n_res.center_x = f.sx ? $signed(-f.qx) : $signed(f.qx);
        end
        if (f.cyo || (f.qy[CQW-1] && (!f.sy || (f.qy[CQW-2:0] != '0)))) begin
            n_res.center_y = f.sy ? ccircle_pkg::CTR_MIN : ccircle_pkg::CTR_MAX;
            sat = 1'b1;
        end else begin
            n_res.center_y = f.sy ? $signed(-f.qy) : $signed(f.qy);
        end
        if (f.rovf) begin
            n_res.radius_q4 = ccircle_pkg::RAD_MAX;
            sat = 1'b1;
        end else begin
            n_res.radius_q4 = f.rq;
        end
        n_res.degenerate = f.deg;
        n_res.saturated  = sat;
        if (f.deg) begin
            n_res.center_x  = '0;
            n_res.center_y  = '0;
            n_res.radius_q4 = '0;
            n_res.saturated = 1'b0;
        end
    end

    // Two-word output buffer
    assign push = adv && r_pipe[NI].valid;
    assign pop  = (r_cnt != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= n_res;
        end
    end

    assign o_valid      = (r_cnt != 2'd0);
    assign o_center_x   = r_buf[r_rp].center_x;
    assign o_center_y   = r_buf[r_rp].center_y;
    assign o_radius_q4  = r_buf[r_rp].radius_q4;
    assign o_degenerate = r_buf[r_rp].degenerate;
    assign o_saturated  = r_buf[r_rp].saturated;

endmodule

// File: tb/circumcircle_from_three_points_tb.sv
// Testbench: random and directed point triples checked against an exact integer circle predictor.
`timescale 1ns / 1ps

module circumcircle_from_three_points_tb;

    localparam int CB         = ccircle_pkg::COORD_BITS;
    localparam int CMAX       = (1 << CB) - 1;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_WAIT = 300;

    // One triple of points, plus a request to let the pipe empty before it
    typedef struct {
        logic [5:0][CB-1:0] pt;
        bit                 drain_first;
    } t_triple;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_valid = 1'b0;
    logic                                  o_stall;
    logic [CB-1:0]                         i_first_x = '0, i_first_y = '0;
    logic [CB-1:0]                         i_second_x = '0, i_second_y = '0;
    logic [CB-1:0]                         i_third_x = '0, i_third_y = '0;
    logic                                  o_valid;
    logic                                  i_stall = 1'b0;
    logic signed [ccircle_pkg::CTR_W-1:0]  o_center_x, o_center_y;
    logic [ccircle_pkg::RAD_W-1:0]         o_radius_q4;
    logic                                  o_degenerate, o_saturated;

    t_triple           pending_triples[$];
    ccircle_pkg::t_res expected_circles[$];
    int      error_count = 0;
    int      send_gap = 0;
    int      idle_cycles = 0;
    bit      send_calm = 1'b0;
    bit      recv_calm = 1'b0;

    circumcircle_from_three_points dut (.*);

    always #1 i_clk = ~i_clk;

    // Exact circumcircle of one triple
    function automatic ccircle_pkg::t_res circle_of(input logic [5:0][CB-1:0] pt);
        longint x1, y1, x2, y2, x3, y3, ax, ay, bx, by, det, adet;
        longint s1, s2, s3, bc2, cd2, nx, ny, den, cx, cy, uu, vv, ww;
        logic [127:0] prod, d2;
        logic [63:0] q, bitv;
        ccircle_pkg::t_res r;
        x1 = pt[0]; y1 = pt[1]; x2 = pt[2]; y2 = pt[3]; x3 = pt[4]; y3 = pt[5];
        ax = x1 - x2; ay = y1 - y2; bx = x2 - x3; by = y2 - y3;
        det = ax * by - bx * ay;
        r = '0;
        if (det == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        s1 = x1 * x1 + y1 * y1;
        s2 = x2 * x2 + y2 * y2;
        s3 = x3 * x3 + y3 * y3;
        bc2 = s1 - s2;
        cd2 = s2 - s3;
        nx = bc2 * by - cd2 * ay;
        ny = cd2 * ax - bc2 * bx;
        den = 2 * det;
        cx = nx / den;   // truncates toward zero
        cy = ny / den;
        if (cx > 8388607)  begin cx = 8388607;  r.saturated = 1'b1; end
        if (cx < -8388608) begin cx = -8388608; r.saturated = 1'b1; end
        if (cy > 8388607)  begin cy = 8388607;  r.saturated = 1'b1; end
        if (cy < -8388608) begin cy = -8388608; r.saturated = 1'b1; end
        r.center_x = cx[ccircle_pkg::CTR_W-1:0];
        r.center_y = cy[ccircle_pkg::CTR_W-1:0];
        // r^2 * 4 det^2 = product of squared sides, scaled to the fraction
        uu = ax * ax + ay * ay;
        vv = bx * bx + by * by;
        ww = (x1 - x3) * (x1 - x3) + (y1 - y3) * (y1 - y3);
        prod = 128'(uu) * 128'(vv) * 128'(ww);
        prod = prod << (2 * ccircle_pkg::RADIUS_FRAC_BITS);
        adet = (det < 0) ? -det : det;
        d2 = 128'(adet) * 128'(adet) * 128'd4;
        q = 64'd1 << ccircle_pkg::RAD_W;
        if (d2 * (128'(q) * 128'(q)) <= prod) begin
            r.radius_q4 = ccircle_pkg::RAD_MAX;
            r.saturated = 1'b1;
        end else begin
            q = 0;
            for (bitv = 64'd1 << (ccircle_pkg::RAD_W - 1); bitv != 0; bitv = bitv >> 1)
                if (d2 * (128'(q | bitv) * 128'(q | bitv)) <= prod)
                    q = q | bitv;
            r.radius_q4 = q[ccircle_pkg::RAD_W-1:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int u;
        u = $urandom_range(0, 99);
        if (u < 65) return 0;
        if (u < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_triple make_triple(input int a, b, c, d, e, f, input bit drain);
        t_triple t;
        t.pt = {CB'(f), CB'(e), CB'(d), CB'(c), CB'(b), CB'(a)};
        t.drain_first = drain;
        return t;
    endfunction

    // Append one triple to the send queue
    function automatic void queue_triple(input t_triple t);
        pending_triples.insert(pending_triples.size(), t);
    endfunction

    // Sender: hold the word while stalled, otherwise record acceptance and load the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid)
                expected_circles.insert(expected_circles.size(),
                                        circle_of({i_third_y, i_third_x, i_second_y,
                                                   i_second_x, i_first_y, i_first_x}));
            if ($urandom_range(0, 299) == 0)
                send_calm <= ~send_calm;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (pending_triples.size() > 0 &&
                         (!pending_triples[0].drain_first ||
                          (!i_valid && expected_circles.size() == 0))) begin
                t_triple t;
                t = pending_triples.pop_front();
                {i_third_y, i_third_x, i_second_y, i_second_x, i_first_y, i_first_x} <= t.pt;
                i_valid  <= 1'b1;
                send_gap <= send_calm ? 0 : pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall and check of every accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_circles.size() == 0) begin
                    $display("%0t: result with none expected: cx=%0d cy=%0d r=%0d",
                             $time, o_center_x, o_center_y, o_radius_q4);
                    error_count++;
                end else begin
                    ccircle_pkg::t_res e;
                    e = expected_circles.pop_front();
                    if (o_center_x !== e.center_x) begin
                        $display("%0t: center_x expected %0d got %0d",
                                 $time, e.center_x, o_center_x);
                        error_count++;
                    end
                    if (o_center_y !== e.center_y) begin
                        $display("%0t: center_y expected %0d got %0d",
                                 $time, e.center_y, o_center_y);
                        error_count++;
                    end
                    if (o_radius_q4 !== e.radius_q4) begin
                        $display("%0t: radius_q4 expected %0d got %0d",
                                 $time, e.radius_q4, o_radius_q4);
                        error_count++;
                    end
                    if (o_degenerate !== e.degenerate) begin
                        $display("%0t: degenerate expected %0b got %0b",
                                 $time, e.degenerate, o_degenerate);
                        error_count++;
                    end
                    if (o_saturated !== e.saturated) begin
                        $display("%0t: saturated expected %0b got %0b",
                                 $time, e.saturated, o_saturated);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 299) == 0)
                recv_calm <= ~recv_calm;
            if (recv_calm)
                i_stall <= 1'b0;
            else if (i_stall)
                i_stall <= ($urandom_range(0, 99) < 60) ||
                           ($urandom_range(0, 99) < 3);
            else
                i_stall <= $urandom_range(0, 99) < 20;
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int ox, oy, dx, dy, k, m, lim;
        // Directed: extremes, degenerate shapes, near-collinear saturation
        queue_triple(make_triple(0, 0, 0, 0, 0, 0, 0));
        queue_triple(make_triple(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0));
        queue_triple(make_triple(0, 0, 10, 10, 20, 20, 0));
        queue_triple(make_triple(5, 5, 5, 5, 100, 7, 0));
        queue_triple(make_triple(0, 0, CMAX, CMAX, 17, 17, 0));
        queue_triple(make_triple(0, 0, CMAX, 0, 0, CMAX, 0));
        queue_triple(make_triple(CMAX, CMAX, 0, CMAX, CMAX, 0, 0));
        queue_triple(make_triple(0, 0, 1, 0, 0, 1, 0));
        queue_triple(make_triple(1, 0, 0, 1, 0, 0, 0));
        queue_triple(make_triple(0, 0, CMAX, 1, CMAX - 1, 1, 0));
        queue_triple(make_triple(0, 0, CMAX, CMAX - 1, CMAX - 1, CMAX - 2, 0));
        queue_triple(make_triple(0, 0, CMAX, 1, 1, 0, 0));
        queue_triple(make_triple(0, CMAX, CMAX, 0, 1, CMAX - 1, 0));
        queue_triple(make_triple(0, 0, 2048, 1, CMAX, 0, 0));
        queue_triple(make_triple(0, 0, 2048, 1, CMAX, 1, 0));
        queue_triple(make_triple(CMAX, 0, 0, CMAX, 2048, 2048, 0));
        queue_triple(make_triple(100, 200, 300, 400, 200, 100, 0));
        queue_triple(make_triple(2048, 0, 0, 2048, CMAX, 2048, 0));
        queue_triple(make_triple(CMAX, 1, 1, CMAX, 0, 0, 0));
        queue_triple(make_triple(3000, 3000, 3001, 3000, 3000, 3001, 1));
        // Random: full range, small clusters, near-collinear
        for (int n = 0; n < 1000; n++) begin
            m = $urandom_range(0, 9);
            if (m < 4) begin
                queue_triple(make_triple(
                    $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                    $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                    $urandom_range(0, CMAX), $urandom_range(0, CMAX), n == 500));
            end else if (m < 7) begin
                lim = (m == 4) ? 3 : 64;
                ox = $urandom_range(0, CMAX - lim);
                oy = $urandom_range(0, CMAX - lim);
                queue_triple(make_triple(
                    ox + $urandom_range(0, lim), oy + $urandom_range(0, lim),
                    ox + $urandom_range(0, lim), oy + $urandom_range(0, lim),
                    ox + $urandom_range(0, lim), oy + $urandom_range(0, lim), n == 500));
            end else begin
                // third point on or one step off the line through the first two
                ox = $urandom_range(0, CMAX / 2);
                oy = $urandom_range(0, CMAX / 2);
                dx = $urandom_range(0, 40);
                dy = $urandom_range(0, 40);
                k  = $urandom_range(2, 50);
                if (ox + k * dx > CMAX - 1) k = (CMAX - 1 - ox) / (dx + 1) + 1;
                if (oy + k * dy > CMAX - 1) k = 1;
                queue_triple(make_triple(
                    ox, oy, ox + dx, oy + dy,
                    ox + k * dx + $urandom_range(0, 1), oy + k * dy + $urandom_range(0, 1),
                    n == 500));
            end
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_triples.size() == 0 && !i_valid && expected_circles.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && expected_circles.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
